// ===== hw/rtl/gpm_pkg.sv =====
// ----------------------------------------------------------------------------
// gpm_pkg
// Shared types, codes and defaults of the glyph profile matcher.
// ----------------------------------------------------------------------------
package gpm_pkg;

    localparam int unsigned MAX_CELL_WIDTH_DEF  = 16;
    localparam int unsigned MAX_CELL_HEIGHT_DEF = 16;
    localparam int unsigned MAX_GLYPHS_DEF      = 128;
    localparam int unsigned MAX_IGNORE_DEF      = 4;

    localparam int unsigned NUM_IGNORE_REGS = 4;
    // clamped cell size, holds up to 63
    localparam int unsigned SIZE_W = 6;

    localparam logic [4:0]  RST_CELL_WIDTH   = 5'd8;
    localparam logic [4:0]  RST_CELL_HEIGHT  = 5'd12;
    localparam logic [2:0]  RST_IGNORE_COUNT = 3'd1;
    localparam logic [31:0] RGB_MASK         = 32'h00FF_FFFF;

    typedef enum logic [2:0] {
        CFG_CELL_WIDTH   = 3'd0,
        CFG_CELL_HEIGHT  = 3'd1,
        CFG_IGNORE_COUNT = 3'd2,
        CFG_IGNORE_0     = 3'd3,
        CFG_IGNORE_1     = 3'd4,
        CFG_IGNORE_2     = 3'd5,
        CFG_IGNORE_3     = 3'd6,
        CFG_UNUSED       = 3'd7
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_MATCHED  = 3'd0,
        ST_NO_MATCH = 3'd1,
        ST_STORED   = 3'd2,
        ST_REPLACED = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    localparam logic CMD_LEARN = 1'b0;

    typedef struct packed {
        logic        command;
        logic [31:0] pixel_color;
        logic [7:0]  glyph_code;
    } t_pixel;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] char_code;
    } t_result;

    // end-of-cell control that travels with a queued profile
    typedef struct packed {
        logic              learn;
        logic [7:0]        code;
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/gpm_front.sv =====
// ----------------------------------------------------------------------------
// gpm_front
// Pixel classifier and profile counter with a one-entry cell queue.
// ----------------------------------------------------------------------------
module gpm_front #(
    parameter int unsigned MAX_CELL_WIDTH  = gpm_pkg::MAX_CELL_WIDTH_DEF,
    parameter int unsigned MAX_CELL_HEIGHT = gpm_pkg::MAX_CELL_HEIGHT_DEF,
    localparam int unsigned XW = (MAX_CELL_WIDTH  > 1) ? $clog2(MAX_CELL_WIDTH)  : 1,
    localparam int unsigned YW = (MAX_CELL_HEIGHT > 1) ? $clog2(MAX_CELL_HEIGHT) : 1,
    localparam int unsigned RW = $clog2(MAX_CELL_WIDTH + 1),
    localparam int unsigned CW = $clog2(MAX_CELL_HEIGHT + 1)
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_take,
    input  gpm_pkg::t_pixel                         i_pixel,
    input  logic [gpm_pkg::SIZE_W-1:0]              i_w,
    input  logic [gpm_pkg::SIZE_W-1:0]              i_h,
    input  logic [3:0]                              i_ign_n,
    input  logic [gpm_pkg::NUM_IGNORE_REGS-1:0][31:0] i_ign_colors,
    output logic                                    o_q_valid,
    output gpm_pkg::t_cell_ctl                      o_q_ctl,
    output logic [MAX_CELL_HEIGHT-1:0][RW-1:0]      o_q_rows,
    output logic [MAX_CELL_WIDTH-1:0][CW-1:0]       o_q_cols,
    input  logic                                    i_q_pop
);

    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic [RW-1:0] r_row_cnt;
    logic [MAX_CELL_WIDTH-1:0][CW-1:0]  r_cols, n_cols;
    logic [MAX_CELL_HEIGHT-1:0][RW-1:0] r_rows, n_rows;
    logic          r_q_valid;
    gpm_pkg::t_cell_ctl                 r_q_ctl;
    logic [MAX_CELL_HEIGHT-1:0][RW-1:0] r_q_rows;
    logic [MAX_CELL_WIDTH-1:0][CW-1:0]  r_q_cols;

    logic                      hit, counted, row_end, cell_end;
    logic [RW-1:0]             row_new;
    logic [gpm_pkg::SIZE_W-1:0] x_inc, y_inc;

    always_comb begin
        hit = 1'b0;
        for (int k = 0; k < gpm_pkg::NUM_IGNORE_REGS; k++) begin
            if ((4'(k) < i_ign_n) && (i_ign_colors[k] == i_pixel.pixel_color)) begin
                hit = 1'b1;
            end
        end
        if (i_pixel.command == gpm_pkg::CMD_LEARN) begin
            counted = (i_pixel.pixel_color & gpm_pkg::RGB_MASK) != 32'd0;
        end else begin
            counted = !hit;
        end
        row_new  = r_row_cnt + RW'(counted);
        x_inc    = gpm_pkg::SIZE_W'(r_x) + 1'b1;
        y_inc    = gpm_pkg::SIZE_W'(r_y) + 1'b1;
        row_end  = x_inc >= i_w;
        cell_end = row_end && (y_inc >= i_h);
        n_cols   = r_cols;
        n_cols[r_x] = r_cols[r_x] + CW'(counted);
        n_rows   = r_rows;
        n_rows[r_y] = row_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x       <= '0;
            r_y       <= '0;
            r_row_cnt <= '0;
            r_cols    <= '0;
            r_q_valid <= 1'b0;
        end else begin
            if (i_q_pop) begin
                r_q_valid <= 1'b0;
            end
            if (i_take) begin
                r_cols <= n_cols;
                if (!row_end) begin
                    r_x       <= XW'(x_inc);
                    r_row_cnt <= row_new;
                end else begin
                    r_x       <= '0;
                    r_row_cnt <= '0;
                    if (!cell_end) begin
                        r_y <= YW'(y_inc);
                    end else begin
                        // hand the finished cell to the back end, restart columns
                        r_y       <= '0;
                        r_cols    <= '0;
                        r_q_valid <= 1'b1;
                    end
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_take && row_end) begin
            r_rows <= n_rows;
        end
        if (i_take && cell_end) begin
            r_q_ctl.learn <= i_pixel.command == gpm_pkg::CMD_LEARN;
            r_q_ctl.code  <= i_pixel.glyph_code;
            r_q_ctl.w     <= i_w;
            r_q_ctl.h     <= i_h;
            r_q_rows      <= n_rows;
            r_q_cols      <= n_cols;
        end
    end

    assign o_q_valid = r_q_valid;
    assign o_q_ctl   = r_q_ctl;
    assign o_q_rows  = r_q_rows;
    assign o_q_cols  = r_q_cols;

endmodule

// ===== hw/rtl/gpm_back.sv =====
// ----------------------------------------------------------------------------
// gpm_back
// Glyph table: searches stored profiles, learns and replaces entries.
// ----------------------------------------------------------------------------
module gpm_back #(
    parameter int unsigned MAX_CELL_WIDTH  = gpm_pkg::MAX_CELL_WIDTH_DEF,
    parameter int unsigned MAX_CELL_HEIGHT = gpm_pkg::MAX_CELL_HEIGHT_DEF,
    parameter int unsigned MAX_GLYPHS      = gpm_pkg::MAX_GLYPHS_DEF,
    localparam int unsigned RW = $clog2(MAX_CELL_WIDTH + 1),
    localparam int unsigned CW = $clog2(MAX_CELL_HEIGHT + 1),
    localparam int unsigned MW = MAX_CELL_HEIGHT * RW + MAX_CELL_WIDTH * CW,
    localparam int unsigned AW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1,
    localparam int unsigned GW = $clog2(MAX_GLYPHS + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  gpm_pkg::t_cell_ctl                 i_ctl,
    input  logic [MAX_CELL_HEIGHT-1:0][RW-1:0] i_rows,
    input  logic [MAX_CELL_WIDTH-1:0][CW-1:0]  i_cols,
    output logic                               o_result_valid,
    output gpm_pkg::t_result                   o_result
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SRCH = 3'b010,
        S_CMP  = 3'b100
    } t_state;

    t_state r_state;
    logic [GW-1:0] r_g, r_count;
    gpm_pkg::t_cell_ctl                 r_ctl;
    logic [MAX_CELL_HEIGHT-1:0][RW-1:0] r_rows;
    logic [MAX_CELL_WIDTH-1:0][CW-1:0]  r_cols;
    logic [MW-1:0] r_prof_mem [MAX_GLYPHS];
    logic [7:0]    r_code_mem [MAX_GLYPHS];
    logic [MW-1:0] r_rd_prof;
    logic [7:0]    r_rd_code;
    logic          r_out_valid;
    gpm_pkg::t_result r_out;

    logic [MAX_CELL_HEIGHT-1:0][RW-1:0] rd_rows, wr_rows;
    logic [MAX_CELL_WIDTH-1:0][CW-1:0]  rd_cols, wr_cols;
    logic           match, fin, we_prof, we_code;
    logic [AW-1:0]  waddr;
    gpm_pkg::t_result res;

    assign {rd_rows, rd_cols} = r_rd_prof;

    always_comb begin
        match = 1'b1;
        for (int i = 0; i < MAX_CELL_HEIGHT; i++) begin
            if ((gpm_pkg::SIZE_W'(i) < r_ctl.h) && (rd_rows[i] != r_rows[i])) begin
                match = 1'b0;
            end
            wr_rows[i] = (gpm_pkg::SIZE_W'(i) < r_ctl.h) ? r_rows[i] : '0;
        end
        for (int i = 0; i < MAX_CELL_WIDTH; i++) begin
            if ((gpm_pkg::SIZE_W'(i) < r_ctl.w) && (rd_cols[i] != r_cols[i])) begin
                match = 1'b0;
            end
            wr_cols[i] = (gpm_pkg::SIZE_W'(i) < r_ctl.w) ? r_cols[i] : '0;
        end

        fin     = 1'b0;
        we_prof = 1'b0;
        we_code = 1'b0;
        waddr   = r_g[AW-1:0];
        res     = '0;
        if ((r_state == S_CMP) && match) begin
            fin = 1'b1;
            if (r_ctl.learn) begin
                we_code       = 1'b1;
                res.status    = gpm_pkg::ST_REPLACED;
                res.char_code = r_ctl.code;
            end else begin
                res.status    = gpm_pkg::ST_MATCHED;
                res.char_code = r_rd_code;
            end
        end else if ((r_state == S_SRCH) && (r_g >= r_count)) begin
            fin   = 1'b1;
            waddr = r_count[AW-1:0];
            if (!r_ctl.learn) begin
                res.status = gpm_pkg::ST_NO_MATCH;
            end else if (r_count < GW'(MAX_GLYPHS)) begin
                we_prof       = 1'b1;
                we_code       = 1'b1;
                res.status    = gpm_pkg::ST_STORED;
                res.char_code = r_ctl.code;
            end else begin
                res.status = gpm_pkg::ST_FULL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_g         <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= fin;
            if (we_prof) begin
                r_count <= r_count + 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    r_g <= '0;
                    if (i_valid) begin
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    r_state <= fin ? S_IDLE : S_CMP;
                end
                S_CMP: begin
                    // step to the next stored glyph; a match ends the search instead
                    r_g     <= r_g + 1'b1;
                    r_state <= fin ? S_IDLE : S_SRCH;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_valid) begin
            r_ctl  <= i_ctl;
            r_rows <= i_rows;
            r_cols <= i_cols;
        end
        r_rd_prof <= r_prof_mem[r_g[AW-1:0]];
        r_rd_code <= r_code_mem[r_g[AW-1:0]];
        if (we_prof) begin
            r_prof_mem[waddr] <= {wr_rows, wr_cols};
        end
        if (we_code) begin
            r_code_mem[waddr] <= r_ctl.code;
        end
        r_out <= res;
    end

    assign o_ready        = r_state == S_IDLE;
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |=> !r_out_valid)
        else $error("two results back to back");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= GW'(MAX_GLYPHS))
        else $error("glyph count past table size");
    a_cmp_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ($past(r_state) == S_SRCH))
        else $error("compare without a table read");
    a_result_from_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($past(r_state) != S_IDLE))
        else $error("result while idle");

endmodule

// ===== hw/rtl/glyph_profile_matcher.sv =====
// ----------------------------------------------------------------------------
// glyph_profile_matcher
// Character recognition by row and column projection profiles.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels of one character cell enter in raster order, x fastest, one per
//   transaction on the command channel (i_start while o_busy is low). Each
//   pixel is counted in learn mode when its RGB bits are nonzero, in
//   classify mode unless it equals an enabled ignore color.
//   The last pixel of a cell queues the cell profile for the glyph table.
//   The table side walks the stored glyphs, for each one a registered
//   memory read and then a full-profile compare, and ends the search at
//   the first hit or after the last stored glyph. One result per cell,
//   a one-cycle strobe on o_result_valid; the receiver cannot stall.
//   Pixels go in at one per cycle while o_busy is low. o_busy is high
//   while a finished cell waits in the one-entry queue: from the edge that
//   takes the last pixel of a cell until the table is idle and takes the
//   cell, so also until any previous search ends.
//   Configuration writes on the cfg channel are always taken (o_cfg_ready
//   high); write them only while no cell is in progress in the table.
//   Reset clears counters, the glyph count and the registers to defaults;
//   the glyph memories need no clearing pass since only entries below the
//   glyph count are compared.
// ----------------------------------------------------------------------------
module glyph_profile_matcher #(
    parameter int unsigned MAX_CELL_WIDTH  = gpm_pkg::MAX_CELL_WIDTH_DEF,
    parameter int unsigned MAX_CELL_HEIGHT = gpm_pkg::MAX_CELL_HEIGHT_DEF,
    parameter int unsigned MAX_GLYPHS      = gpm_pkg::MAX_GLYPHS_DEF,
    parameter int unsigned MAX_IGNORE      = gpm_pkg::MAX_IGNORE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  gpm_pkg::t_pixel    i_pixel,
    output logic               o_result_valid,
    output gpm_pkg::t_result   o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int unsigned RW = $clog2(MAX_CELL_WIDTH + 1);
    localparam int unsigned CW = $clog2(MAX_CELL_HEIGHT + 1);
    localparam int unsigned IGN_LIM =
        (MAX_IGNORE < gpm_pkg::NUM_IGNORE_REGS) ? MAX_IGNORE : gpm_pkg::NUM_IGNORE_REGS;

    logic [4:0] r_cell_width, r_cell_height;
    logic [2:0] r_ignore_count;
    logic [gpm_pkg::NUM_IGNORE_REGS-1:0][31:0] r_ign;

    logic [gpm_pkg::SIZE_W-1:0] w_eff, h_eff;
    logic [3:0]                 ign_n;
    logic                       take, q_valid, q_pop, back_ready;
    gpm_pkg::t_cell_ctl         q_ctl;
    logic [MAX_CELL_HEIGHT-1:0][RW-1:0] q_rows;
    logic [MAX_CELL_WIDTH-1:0][CW-1:0]  q_cols;

    // register file, written at any time the channel is valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_width   <= gpm_pkg::RST_CELL_WIDTH;
            r_cell_height  <= gpm_pkg::RST_CELL_HEIGHT;
            r_ignore_count <= gpm_pkg::RST_IGNORE_COUNT;
            r_ign          <= '0;
        end else if (i_cfg_valid) begin
            case (gpm_pkg::t_cfg_index'(i_cfg_index))
                gpm_pkg::CFG_CELL_WIDTH:   r_cell_width   <= i_cfg_data[4:0];
                gpm_pkg::CFG_CELL_HEIGHT:  r_cell_height  <= i_cfg_data[4:0];
                gpm_pkg::CFG_IGNORE_COUNT: r_ignore_count <= i_cfg_data[2:0];
                gpm_pkg::CFG_IGNORE_0:     r_ign[0]       <= i_cfg_data;
                gpm_pkg::CFG_IGNORE_1:     r_ign[1]       <= i_cfg_data;
                gpm_pkg::CFG_IGNORE_2:     r_ign[2]       <= i_cfg_data;
                gpm_pkg::CFG_IGNORE_3:     r_ign[3]       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero size acts as one, oversize saturates; ignore count saturates too
    always_comb begin
        if (r_cell_width == 5'd0) begin
            w_eff = gpm_pkg::SIZE_W'(1);
        end else if (32'(r_cell_width) > MAX_CELL_WIDTH) begin
            w_eff = gpm_pkg::SIZE_W'(MAX_CELL_WIDTH);
        end else begin
            w_eff = gpm_pkg::SIZE_W'(r_cell_width);
        end
        if (r_cell_height == 5'd0) begin
            h_eff = gpm_pkg::SIZE_W'(1);
        end else if (32'(r_cell_height) > MAX_CELL_HEIGHT) begin
            h_eff = gpm_pkg::SIZE_W'(MAX_CELL_HEIGHT);
        end else begin
            h_eff = gpm_pkg::SIZE_W'(r_cell_height);
        end
        ign_n = (32'(r_ignore_count) > IGN_LIM) ? 4'(IGN_LIM) : 4'(r_ignore_count);
    end

    assign o_cfg_ready = 1'b1;
    assign o_busy      = q_valid;
    assign take        = i_start && !q_valid;
    assign q_pop       = q_valid && back_ready;

    gpm_front #(
        .MAX_CELL_WIDTH  (MAX_CELL_WIDTH),
        .MAX_CELL_HEIGHT (MAX_CELL_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_pixel      (i_pixel),
        .i_w          (w_eff),
        .i_h          (h_eff),
        .i_ign_n      (ign_n),
        .i_ign_colors (r_ign),
        .o_q_valid    (q_valid),
        .o_q_ctl      (q_ctl),
        .o_q_rows     (q_rows),
        .o_q_cols     (q_cols),
        .i_q_pop      (q_pop)
    );

    gpm_back #(
        .MAX_CELL_WIDTH  (MAX_CELL_WIDTH),
        .MAX_CELL_HEIGHT (MAX_CELL_HEIGHT),
        .MAX_GLYPHS      (MAX_GLYPHS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .o_ready        (back_ready),
        .i_ctl          (q_ctl),
        .i_rows         (q_rows),
        .i_cols         (q_cols),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule
